// ===== sv/frame_header_checker_assert.svh =====
// ---------------------------------------------------------------------------
// Frame header checker assertion macros
// Shared concurrent assertion forms used by the checker's RTL modules.
// ---------------------------------------------------------------------------
`ifndef FRAME_HEADER_CHECKER_ASSERT_SVH
`define FRAME_HEADER_CHECKER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define FHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define FHC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/fhc_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame header checker package
// Word types, header layout constants, verdict codes and register indexes.
// ---------------------------------------------------------------------------
package fhc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION     = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;
  localparam logic [7:0] VERSION_RST     = 8'd1;

  // Header byte positions within a buffer.
  localparam logic [8:0] HDR_SYNC0     = 9'd0;
  localparam logic [8:0] HDR_SYNC1     = 9'd1;
  localparam logic [8:0] HDR_VERSION   = 9'd2;
  localparam logic [8:0] HDR_TYPE      = 9'd3;
  localparam logic [8:0] HDR_SENDER_LO = 9'd4;
  localparam logic [8:0] HDR_SENDER_HI = 9'd5;
  localparam logic [8:0] HDR_SEQ_LO    = 9'd6;
  localparam logic [8:0] HDR_SEQ_HI    = 9'd7;
  localparam logic [8:0] HDR_FLAGS     = 9'd8;
  localparam logic [8:0] HDR_LENGTH    = 9'd9;
  localparam logic [8:0] HDR_CHECKSUM  = 9'd10;
  localparam logic [8:0] HDR_LEN       = 9'd11;
  localparam logic [8:0] INDEX_MAX     = 9'd511;

  // Fault mark bit positions.
  localparam int unsigned MARK_SYNC = 0;
  localparam int unsigned MARK_VER  = 1;
  localparam int unsigned MARK_SUM  = 2;

  // Result word kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Default depth of the result queue.
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT_HDR   = 3'd1,
    ST_BAD_SYNC    = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_SHORT_PAY   = 3'd4,
    ST_BAD_SUM     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [7:0]  frame_type;
    logic [15:0] source_id;
    logic [15:0] seq_num;
    logic [7:0]  flags;
    logic [7:0]  body_len;
    logic [7:0]  checksum_byte;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] version;
  } cfg_t;

  // Up to two result words handed to the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

endpackage

// ===== sv/fhc_result_fifo.sv =====
// ---------------------------------------------------------------------------
// Frame header checker result queue
// Small register queue that takes up to two result words a cycle and hands
// out one word a cycle on the output channel while out_stall_i is low.
// ---------------------------------------------------------------------------
module fhc_result_fifo #(
  parameter int unsigned Depth = fhc_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhc_pkg::push_t    push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fhc_pkg::out_word_t out_data_o
);
  import fhc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_word_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Output side reads the head entry.
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Room for a full two-word push.
  assign room_o = (count_q <= CntW'(Depth - 2));

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nx = ptr_inc(wr_ptr_q);
    case (push_i.cnt)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.word0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.word1;
    end
  end

`include "frame_header_checker_assert.svh"

  `FHC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, (32'(count_q) + 32'(push_i.cnt) > 32'(Depth) + 32'(pop)), "result queue overflow")
  `FHC_ASSERT(a_empty_ptrs, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with unequal pointers")

endmodule

// ===== sv/fhc_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Frame header checker parser
// Input register, per-buffer header state and the single-pass logic that
// forms payload and verdict words for the result queue.
// ---------------------------------------------------------------------------
module fhc_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhc_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fhc_pkg::in_word_t in_data_i,
  input  logic              room_i,
  output fhc_pkg::push_t    push_o
);
  import fhc_pkg::*;

  // Input register.
  logic        in_valid_q;
  in_word_t    in_q;
  logic        fire;

  // Buffer state.
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic [2:0]  fault_q, fault_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] sender_q, sender_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;

  logic [7:0]  b;
  logic [8:0]  total;
  logic        pay;
  logic        show;
  status_e     status;
  out_word_t   pay_word, ver_word;

  // The held word moves on once the queue can take a full push.
  assign fire       = in_valid_q && room_i;
  assign in_stall_o = in_valid_q && !room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Header parsing, payload selection and verdict.
  always_comb begin
    b        = in_q.data_byte;
    xor_d    = xor_q;
    fault_d  = fault_q;
    type_d   = type_q;
    sender_d = sender_q;
    seq_d    = seq_q;
    flags_d  = flags_q;
    len_d    = len_q;
    sum_d    = sum_q;
    pay      = 1'b0;

    if (idx_q < HDR_CHECKSUM) begin
      xor_d = xor_q ^ b;
    end

    case (idx_q)
      HDR_SYNC0:     if (b != cfg_i.sync_first) fault_d[MARK_SYNC] = 1'b1;
      HDR_SYNC1:     if (b != cfg_i.sync_second) fault_d[MARK_SYNC] = 1'b1;
      HDR_VERSION:   if (b != cfg_i.version) fault_d[MARK_VER] = 1'b1;
      HDR_TYPE:      type_d = b;
      HDR_SENDER_LO: sender_d = {sender_q[15:8], b};
      HDR_SENDER_HI: sender_d = {b, sender_q[7:0]};
      HDR_SEQ_LO:    seq_d = {seq_q[15:8], b};
      HDR_SEQ_HI:    seq_d = {b, seq_q[7:0]};
      HDR_FLAGS:     flags_d = b;
      HDR_LENGTH:    len_d = b;
      HDR_CHECKSUM: begin
        sum_d = b;
        if (b != xor_q) fault_d[MARK_SUM] = 1'b1;
      end
      default: begin
        pay = (idx_q < HDR_LEN + {1'b0, len_q}) && (fault_q == 3'd0);
      end
    endcase

    // Byte count including this byte, saturating.
    total = (idx_q < INDEX_MAX) ? idx_q + 9'd1 : idx_q;
    idx_d = total;

    if (total < HDR_LEN) begin
      status = ST_SHORT_HDR;
    end else if (fault_d[MARK_SYNC]) begin
      status = ST_BAD_SYNC;
    end else if (fault_d[MARK_VER]) begin
      status = ST_BAD_VERSION;
    end else if (total < HDR_LEN + {1'b0, len_d}) begin
      status = ST_SHORT_PAY;
    end else if (fault_d[MARK_SUM]) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
    show = (status != ST_SHORT_HDR);

    pay_word.kind          = KIND_PAYLOAD;
    pay_word.payload_byte  = b;
    pay_word.status        = ST_OK;
    pay_word.frame_type    = type_q;
    pay_word.source_id     = sender_q;
    pay_word.seq_num       = seq_q;
    pay_word.flags         = flags_q;
    pay_word.body_len      = len_q;
    pay_word.checksum_byte = sum_q;
    pay_word.last          = 1'b0;

    ver_word.kind          = KIND_VERDICT;
    ver_word.payload_byte  = 8'd0;
    ver_word.status        = status;
    ver_word.frame_type    = show ? type_d : 8'd0;
    ver_word.source_id     = show ? sender_d : 16'd0;
    ver_word.seq_num       = show ? seq_d : 16'd0;
    ver_word.flags         = show ? flags_d : 8'd0;
    ver_word.body_len      = show ? len_d : 8'd0;
    ver_word.checksum_byte = show ? sum_d : 8'd0;
    ver_word.last          = 1'b1;

    // A payload word always goes ahead of the verdict.
    push_o.cnt   = fire ? (2'(pay) + 2'(in_q.buffer_end)) : 2'd0;
    push_o.word0 = pay ? pay_word : ver_word;
    push_o.word1 = ver_word;
  end

  // Buffer state update; a verdict rearms for the next buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      xor_q    <= '0;
      fault_q  <= '0;
      type_q   <= '0;
      sender_q <= '0;
      seq_q    <= '0;
      flags_q  <= '0;
      len_q    <= '0;
      sum_q    <= '0;
    end else if (fire) begin
      if (in_q.buffer_end) begin
        idx_q    <= '0;
        xor_q    <= '0;
        fault_q  <= '0;
        type_q   <= '0;
        sender_q <= '0;
        seq_q    <= '0;
        flags_q  <= '0;
        len_q    <= '0;
        sum_q    <= '0;
      end else begin
        idx_q    <= idx_d;
        xor_q    <= xor_d;
        fault_q  <= fault_d;
        type_q   <= type_d;
        sender_q <= sender_d;
        seq_q    <= seq_d;
        flags_q  <= flags_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
      end
    end
  end

`include "frame_header_checker_assert.svh"

  `FHC_ASSERT(a_rearm, clk_i, rst_ni, (fire && in_q.buffer_end) |=> (idx_q == 9'd0 && fault_q == 3'd0), "state not cleared after verdict")
  `FHC_ASSERT_NEVER(a_clean_payload, clk_i, rst_ni, (push_o.cnt != 2'd0 && push_o.word0.kind == KIND_PAYLOAD && fault_q != 3'd0), "payload passed from a faulty header")

endmodule

// ===== sv/frame_header_checker.sv =====
// ---------------------------------------------------------------------------
// Frame header checker
// Checks the frame header of received buffers and passes payload bytes.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one
// buffer byte per word, with buffer_end set on the final byte. The output
// channel (out_valid_o, out_stall_i, out_data_o) gives payload words for
// bytes past the 11-byte header, up to the declared length, when sync,
// version and checksum are good, and one verdict word on the final byte.
// A final byte that is also payload gives its payload word, then the verdict.
// The configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// sets the two sync bytes and the expected version; it is always ready and
// indexes beyond the list are ignored.
// Path: input word -> input register -> result queue -> output. Throughput:
// one byte per cycle, set by the single-pass parser, while the queue has
// room; the two words of a final byte leave the output one after another.
// Reset clears the buffer state and the result queue and restores the
// default register values. When the receiver stalls, words collect in a
// small result queue and the input stalls once it cannot take two words.
// ---------------------------------------------------------------------------
module frame_header_checker #(
  parameter int unsigned FifoDepth = fhc_pkg::FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fhc_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fhc_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import fhc_pkg::*;

  cfg_t  cfg_q;
  push_t push;
  logic  room;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.version     <= VERSION_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data_i;
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i;
        CFG_VERSION:     cfg_q.version     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Header parser.
  fhc_frame_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue.
  fhc_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
